### rtl/assert_macros.svh
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define CTS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, off while in reset
`define CTS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// what must hold in the cycle after reset
`define CTS_ASSERT_RST(lbl, clk, rst, cons) \
  lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("post-reset check failed");

`endif

### rtl/cts_pkg.sv
package cts_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUT,
    ST_BLANK,
    ST_READ,
    ST_DRAW
  } state_t;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;

  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_W  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_H  = 2'd3;

  localparam logic [7:0]  CHAR_BLANK   = 8'd32;
  localparam logic [7:0]  CHAR_NEWLINE = 8'd10;
  localparam logic [10:0] PIX_MAX      = 11'd2047;

  typedef struct packed {
    logic set_cursor;
    logic home;
    logic load_char;
    logic start_line;
    logic start_all;
    logic fill_blank;
    logic emit_put;
    logic emit_blank;
    logic emit_cell;
    logic clear_cell;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic walk_col_last;
    logic walk_last;
    logic cur_col_last;
    logic cur_row_last;
  } dp_stat_t;

endpackage

### rtl/text_console_scroller_core.sv
// put character: taken in idle; the put state stores it and loads the output word when free
// newline: one blank word per cycle, when the output is free, from cursor column to row end
// scroll and clear: every cell redrawn, read from the store in READ and written in DRAW
// reset: cursor home, origins 0, glyph size 8x8; the store is then filled with spaces
// while cmd_stall stays high
module text_console_scroller_core #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_stall,
  input  logic [1:0]                        command,
  input  logic [7:0]                        char_code,
  input  logic [3:0]                        cursor_col,
  input  logic                              cursor_row,
  output logic                              draw_valid,
  input  logic                              draw_stall,
  output logic [7:0]                        glyph_code,
  output logic [10:0]                       pixel_x,
  output logic [10:0]                       pixel_y,
  output logic                              last_draw,
  input  logic                              cfg_en,
  input  logic [cts_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cts_pkg::CFG_DATA_W-1:0]    cfg_data
);

  cts_pkg::dp_cmd_t  dp_cmd;
  cts_pkg::dp_stat_t dp_stat;

  cts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .command  (command),
    .char_code(char_code),
    .stat     (dp_stat),
    .cmd      (dp_cmd),
    .cmd_stall(cmd_stall)
  );

  cts_datapath #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .char_code (char_code),
    .cursor_col(cursor_col),
    .cursor_row(cursor_row),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .draw_valid(draw_valid),
    .draw_stall(draw_stall),
    .glyph_code(glyph_code),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .last_draw (last_draw)
  );

endmodule

### rtl/cts_ram.sv
module cts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/cts_ctrl.sv
module cts_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  logic [1:0]         command,
  input  logic [7:0]         char_code,
  input  cts_pkg::dp_stat_t  stat,
  output cts_pkg::dp_cmd_t   cmd,
  output logic               cmd_stall
);

  cts_pkg::state_t state;
  cts_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cts_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cts_pkg::ST_CLEAR: begin
        if (stat.walk_last) state_next = cts_pkg::ST_IDLE;
      end
      cts_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          case (command)
            cts_pkg::CMD_PUT: begin
              state_next = (char_code == cts_pkg::CHAR_NEWLINE) ?
                           cts_pkg::ST_BLANK : cts_pkg::ST_PUT;
            end
            cts_pkg::CMD_CLEAR: state_next = cts_pkg::ST_READ;
            default: state_next = cts_pkg::ST_IDLE;
          endcase
        end
      end
      cts_pkg::ST_PUT: begin
        if (stat.out_free) begin
          state_next = (stat.cur_col_last && stat.cur_row_last) ?
                       cts_pkg::ST_READ : cts_pkg::ST_IDLE;
        end
      end
      cts_pkg::ST_BLANK: begin
        if (stat.out_free && stat.walk_col_last) begin
          state_next = stat.cur_row_last ? cts_pkg::ST_READ : cts_pkg::ST_IDLE;
        end
      end
      cts_pkg::ST_READ: state_next = cts_pkg::ST_DRAW;
      cts_pkg::ST_DRAW: begin
        if (stat.out_free) begin
          state_next = stat.walk_last ? cts_pkg::ST_IDLE : cts_pkg::ST_READ;
        end
      end
      default: state_next = cts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd_stall = 1'b1;
    case (state)
      cts_pkg::ST_CLEAR: cmd.clear_cell = 1'b1;
      cts_pkg::ST_IDLE: begin
        cmd_stall = 1'b0;
        if (cmd_valid) begin
          case (command)
            cts_pkg::CMD_PUT: begin
              cmd.load_char  = 1'b1;
              cmd.start_line = 1'b1;
            end
            cts_pkg::CMD_SET: cmd.set_cursor = 1'b1;
            cts_pkg::CMD_CLEAR: begin
              cmd.home       = 1'b1;
              cmd.start_all  = 1'b1;
              cmd.fill_blank = 1'b1;
            end
            default: cmd = '0;
          endcase
        end
      end
      cts_pkg::ST_PUT: begin
        if (stat.out_free) begin
          cmd.emit_put  = 1'b1;
          cmd.start_all = stat.cur_col_last && stat.cur_row_last;
        end
      end
      cts_pkg::ST_BLANK: begin
        if (stat.out_free) begin
          cmd.emit_blank = 1'b1;
          cmd.start_all  = stat.walk_col_last && stat.cur_row_last;
        end
      end
      cts_pkg::ST_READ: cmd = '0;
      cts_pkg::ST_DRAW: begin
        if (stat.out_free) cmd.emit_cell = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/cts_datapath.sv
module cts_datapath #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cts_pkg::dp_cmd_t                  cmd,
  output cts_pkg::dp_stat_t                 stat,
  input  logic [7:0]                        char_code,
  input  logic [3:0]                        cursor_col,
  input  logic                              cursor_row,
  input  logic                              cfg_en,
  input  logic [cts_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cts_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              draw_valid,
  input  logic                              draw_stall,
  output logic [7:0]                        glyph_code,
  output logic [10:0]                       pixel_x,
  output logic [10:0]                       pixel_y,
  output logic                              last_draw
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;

  function automatic logic [10:0] pix(logic [9:0] org, logic [5:0] size, logic [5:0] idx);
    logic [11:0] prod;
    logic [12:0] sum;
    prod = 12'(size) * 12'(idx);
    sum  = {3'b000, org} + {1'b0, prod};
    return (sum > 13'(cts_pkg::PIX_MAX)) ? cts_pkg::PIX_MAX : sum[10:0];
  endfunction

  logic [9:0]    origin_x;
  logic [9:0]    origin_y;
  logic [5:0]    glyph_w;
  logic [5:0]    glyph_h;
  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;
  logic [CW-1:0] walk_col;
  logic [RW-1:0] walk_row;
  logic          blank_fill;
  logic [7:0]    char_hold;

  logic          cur_col_last;
  logic          cur_row_last;
  logic          walk_col_last;
  logic          walk_row_last;
  logic [CW-1:0] sel_col;
  logic [RW-1:0] sel_row;
  logic [RW-1:0] rd_row;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [7:0]    wdata;
  logic [7:0]    rdata;
  logic          we;
  logic          load;
  logic          last_sel;

  assign cur_col_last  = (cur_col == CW'(COLUMNS - 1));
  assign cur_row_last  = (cur_row == RW'(ROWS - 1));
  assign walk_col_last = (walk_col == CW'(COLUMNS - 1));
  assign walk_row_last = (walk_row == RW'(ROWS - 1));

  assign stat.out_free      = !draw_valid || !draw_stall;
  assign stat.walk_col_last = walk_col_last;
  assign stat.walk_last     = walk_col_last && walk_row_last;
  assign stat.cur_col_last  = cur_col_last;
  assign stat.cur_row_last  = cur_row_last;

  assign sel_col = cmd.emit_put ? cur_col : walk_col;
  assign sel_row = cmd.emit_put ? cur_row : walk_row;
  assign rd_row  = walk_row_last ? walk_row : walk_row + RW'(1);
  assign waddr   = AW'(int'(sel_row) * COLUMNS + int'(sel_col));
  assign raddr   = AW'(int'(rd_row) * COLUMNS + int'(walk_col));

  assign we   = cmd.emit_put || cmd.emit_blank || cmd.emit_cell || cmd.clear_cell;
  assign load = cmd.emit_put || cmd.emit_blank || cmd.emit_cell;

  always_comb begin
    if (cmd.emit_put) begin
      wdata = char_hold;
    end else if (cmd.emit_cell && !blank_fill && !walk_row_last) begin
      wdata = rdata;
    end else begin
      wdata = cts_pkg::CHAR_BLANK;
    end
  end

  always_comb begin
    if (cmd.emit_put) begin
      last_sel = !(cur_col_last && cur_row_last);
    end else if (cmd.emit_blank) begin
      last_sel = walk_col_last && !cur_row_last;
    end else begin
      last_sel = walk_col_last && walk_row_last;
    end
  end

  cts_ram #(
    .WIDTH(8),
    .DEPTH(CELLS)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      glyph_w  <= 6'd8;
      glyph_h  <= 6'd8;
    end else if (cfg_en) begin
      case (cfg_index)
        cts_pkg::REG_ORIGIN_X: origin_x <= cfg_data;
        cts_pkg::REG_ORIGIN_Y: origin_y <= cfg_data;
        cts_pkg::REG_GLYPH_W:  glyph_w  <= cfg_data[5:0];
        cts_pkg::REG_GLYPH_H:  glyph_h  <= cfg_data[5:0];
        default: origin_x <= origin_x;
      endcase
    end
  end

  // cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
    end else if (cmd.set_cursor) begin
      cur_col <= (int'(cursor_col) >= COLUMNS) ? CW'(COLUMNS - 1) : CW'(cursor_col);
      cur_row <= (int'(cursor_row) >= ROWS) ? RW'(ROWS - 1) : RW'(cursor_row);
    end else if (cmd.home) begin
      cur_col <= '0;
      cur_row <= '0;
    end else if (cmd.emit_put) begin
      if (cur_col_last) begin
        cur_col <= '0;
        cur_row <= cur_row_last ? cur_row : cur_row + RW'(1);
      end else begin
        cur_col <= cur_col + CW'(1);
      end
    end else if (cmd.emit_blank && walk_col_last) begin
      cur_col <= '0;
      cur_row <= cur_row_last ? cur_row : cur_row + RW'(1);
    end
  end

  // store walk
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_col   <= '0;
      walk_row   <= '0;
      blank_fill <= 1'b1;
    end else if (cmd.start_line) begin
      walk_col <= cur_col;
      walk_row <= cur_row;
    end else if (cmd.start_all) begin
      walk_col   <= '0;
      walk_row   <= '0;
      blank_fill <= cmd.fill_blank;
    end else if (cmd.emit_blank) begin
      walk_col <= walk_col + CW'(1);
    end else if (cmd.emit_cell || cmd.clear_cell) begin
      if (walk_col_last) begin
        walk_col <= '0;
        walk_row <= walk_row_last ? '0 : walk_row + RW'(1);
      end else begin
        walk_col <= walk_col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_char) begin
      char_hold <= char_code;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      draw_valid <= 1'b0;
    end else begin
      draw_valid <= load || (draw_valid && draw_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      glyph_code <= wdata;
      pixel_x    <= pix(origin_x, glyph_w, 6'(sel_col));
      pixel_y    <= pix(origin_y, glyph_h, 6'(sel_row));
      last_draw  <= last_sel;
    end
  end

endmodule

### rtl/cts_checker.sv
`include "assert_macros.svh"

module cts_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_stall,
  input logic [1:0]  command,
  input logic        draw_valid,
  input logic        draw_stall,
  input logic [7:0]  glyph_code,
  input logic [10:0] pixel_x,
  input logic [10:0] pixel_y,
  input logic        last_draw
);

  // store fill after reset keeps commands out and no word pending
  `CTS_ASSERT_RST(a_reset_fill, clk, rst, !draw_valid && cmd_stall)

  // a word that is not the last of its command means the sequence still runs
  `CTS_ASSERT_IMP(a_busy_mid_seq, clk, rst, draw_valid && !last_draw, cmd_stall)

  // set cursor produces no word
  `CTS_ASSERT_NXT(a_set_silent, clk, rst, cmd_valid && !cmd_stall && command == cts_pkg::CMD_SET && !draw_valid, !draw_valid)

  `CTS_ASSERT_NXT(a_out_hold, clk, rst, draw_valid && draw_stall, draw_valid && $stable(glyph_code) && $stable(pixel_x) && $stable(pixel_y) && $stable(last_draw))

endmodule

bind text_console_scroller_core cts_checker u_checker (.*);
